/* design/hpc_pkg.sv */
// Package for the heater PWM controller: shared types, register map and constants.
// No dependencies; imported by hpc_cfg, hpc_alu and heater_pwm_controller_top.
package hpc_pkg;

    // Register widths
    localparam int PERIOD_W   = 12;
    localparam int DEBOUNCE_W = 10;
    localparam int REFRESH_W  = 16;
    localparam int THRESH_W   = 12;

    // Item field widths
    localparam int BTN_W  = 2;
    localparam int POT_W  = 12;
    localparam int PCT_W  = 7;
    localparam int TICK_W = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PWM_PERIOD       = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_TICKS   = 2'd1;
    localparam logic [1:0] REG_REFRESH_TICKS    = 2'd2;
    localparam logic [1:0] REG_CHANGE_THRESHOLD = 2'd3;

    // Register reset values
    localparam logic [PERIOD_W-1:0]   RST_PWM_PERIOD       = 12'd2975;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_TICKS   = 10'd30;
    localparam logic [REFRESH_W-1:0]  RST_REFRESH_TICKS    = 16'd500;
    localparam logic [THRESH_W-1:0]   RST_CHANGE_THRESHOLD = 12'd100;

    // Debounced button codes that act on power
    localparam logic [BTN_W-1:0] BTN_CODE_ON   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_CODE_HOLD = 2'd1;

    // Percent divider: numerator pot*1000, divisor (period-5)*10
    localparam int NUM_W     = 22;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = 5;
    localparam logic [PERIOD_W-1:0] PERIOD_OFFSET = 12'd5;
    localparam logic [PCT_W-1:0]    PCT_MAX       = 7'd100;

    // Shared adder/subtractor
    localparam int ALU_W = 32;

    typedef struct packed {
        logic [PERIOD_W-1:0]   pwm_period;
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [REFRESH_W-1:0]  refresh_ticks;
        logic [THRESH_W-1:0]   change_threshold;
    } cfg_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] y;
        logic             borrow;
    } alu_res_t;

endpackage

/* design/heater_pwm_controller_top.sv */
// Heater PWM controller, top level.
// Uses hpc_pkg, hpc_cfg (APB registers) and hpc_alu (shared add/subtract unit).
//
// One input transfer is one millisecond tick: s_tdata carries the two raw button
// levels and the potentiometer code. For each tick the block debounces the
// buttons, switches power on or off, refreshes the duty from the pot (on the
// refresh interval or on a large pot move), recomputes the rounded percent and
// drives a time-proportional heater key from a phase counter. Exactly one result
// transfer leaves on m_tdata/m_tuser per input transfer.
//
// Sequencing: a small sequencer walks one 32-bit adder/subtractor through the tick
// increment, both interval tests, the pot difference, the threshold compare, a
// 22-step restoring division, rounding and the cap for the percent. s_tready is
// high only while the sequencer is idle, so the block takes no new tick before it
// has finished the previous one.
//
// The result sits in an output register; the sequencer accepts the next tick
// while it waits, and only stalls in its final step if m_tready holds the
// previous result. After reset power is off, all counters are zero and the
// registers hold their default values.
module heater_pwm_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [1:0] button_levels, [13:2] pot_code, [15:14] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [0] heater_key, [1] led_out, [2] power_enabled,
                                  // [9:3] percent, [15:10] zero
    output logic        m_tuser   // [0] percent_valid
);
    import hpc_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TICK = 4'd1;
    localparam logic [3:0] S_DEB0 = 4'd2;
    localparam logic [3:0] S_DEB1 = 4'd3;
    localparam logic [3:0] S_DEB2 = 4'd4;
    localparam logic [3:0] S_REF0 = 4'd5;
    localparam logic [3:0] S_REF1 = 4'd6;
    localparam logic [3:0] S_REF2 = 4'd7;
    localparam logic [3:0] S_POT0 = 4'd8;
    localparam logic [3:0] S_POT1 = 4'd9;
    localparam logic [3:0] S_THR  = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_RND  = 4'd12;
    localparam logic [3:0] S_INC  = 4'd13;
    localparam logic [3:0] S_CAP  = 4'd14;
    localparam logic [3:0] S_KEY  = 4'd15;

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_res_t alu_res;

    hpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hpc_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Control state
    logic [3:0]          state_reg,   state_next;
    logic [TICK_W-1:0]   tick_reg,    tick_next;
    logic [TICK_W-1:0]   dmark_reg,   dmark_next;
    logic [TICK_W-1:0]   rmark_reg,   rmark_next;
    logic [BTN_W-1:0]    stable_reg,  stable_next;
    logic                power_reg,   power_next;
    logic [POT_W-1:0]    last_pot_reg, last_pot_next;
    logic [POT_W-1:0]    duty_reg,    duty_next;
    logic [PCT_W-1:0]    pct_reg,     pct_next;
    logic [PERIOD_W-1:0] phase_reg,   phase_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic                m_valid_reg, m_valid_next;

    // Working registers of the current tick
    logic [BTN_W-1:0]    btn_reg,     btn_next;
    logic [POT_W-1:0]    pot_reg,     pot_next;
    logic [TICK_W-1:0]   tmp_reg,     tmp_next;
    logic                due_reg,     due_next;
    logic                pvalid_reg,  pvalid_next;
    logic                round_reg,   round_next;
    logic [NUM_W-1:0]    q_reg,       q_next;
    logic [DEN_W-1:0]    rem_reg,     rem_next;
    logic [DEN_W-1:0]    d_reg,       d_next;
    logic [15:0]         out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;

    // Divider operands: pot*1000 = pot*1024 - pot*16 - pot*8,
    // divisor = (period-5)*10 with a floor of 10.
    logic [NUM_W-1:0]    num_calc;
    logic [PERIOD_W-1:0] pm5;
    logic [DEN_W-1:0]    d_calc;
    logic                key;
    logic [PERIOD_W:0]   phase_inc;
    logic                slot_free;

    assign num_calc = {pot_reg, 10'b0}
                    - {{(NUM_W-POT_W-4){1'b0}}, pot_reg, 4'b0}
                    - {{(NUM_W-POT_W-3){1'b0}}, pot_reg, 3'b0};
    assign pm5      = (cfg.pwm_period > PERIOD_OFFSET) ? (cfg.pwm_period - PERIOD_OFFSET)
                                                       : {{(PERIOD_W-1){1'b0}}, 1'b1};
    assign d_calc   = {1'b0, pm5, 3'b0} + {3'b0, pm5, 1'b0};

    assign key       = power_reg && (phase_reg < duty_reg);
    assign phase_inc = {1'b0, phase_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign slot_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        dmark_next    = dmark_reg;
        rmark_next    = rmark_reg;
        stable_next   = stable_reg;
        power_next    = power_reg;
        last_pot_next = last_pot_reg;
        duty_next     = duty_reg;
        pct_next      = pct_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        btn_next      = btn_reg;
        pot_next      = pot_reg;
        tmp_next      = tmp_reg;
        due_next      = due_reg;
        pvalid_next   = pvalid_reg;
        round_next    = round_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        d_next        = d_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        alu_req.a   = tick_reg;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    btn_next    = s_tdata[BTN_W-1:0];
                    pot_next    = s_tdata[BTN_W+POT_W-1:BTN_W];
                    due_next    = 1'b0;
                    pvalid_next = 1'b0;
                    state_next  = S_TICK;
                end
            end
            S_TICK:
            begin
                // Advance the free-running tick counter
                alu_req.a   = tick_reg;
                alu_req.b   = {{(ALU_W-1){1'b0}}, 1'b1};
                alu_req.sub = 1'b0;
                tick_next   = alu_res.y;
                state_next  = S_DEB0;
            end
            S_DEB0:
            begin
                alu_req.a = tick_reg;
                alu_req.b = dmark_reg;
                tmp_next  = alu_res.y;
                if (btn_reg == stable_reg)
                begin
                    dmark_next = tick_reg;
                    state_next = S_REF0;
                end
                else
                begin
                    state_next = S_DEB1;
                end
            end
            S_DEB1:
            begin
                alu_req.a  = tmp_reg;
                alu_req.b  = {{(ALU_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ticks};
                state_next = alu_res.borrow ? S_REF0 : S_DEB2;
            end
            S_DEB2:
            begin
                // Level persisted long enough: take it and act on power
                alu_req.a   = dmark_reg;
                alu_req.b   = {{(ALU_W-DEBOUNCE_W){1'b0}}, cfg.debounce_ticks};
                alu_req.sub = 1'b0;
                dmark_next  = alu_res.y;
                stable_next = btn_reg;
                case (btn_reg)
                    BTN_CODE_ON:   power_next = 1'b1;
                    BTN_CODE_HOLD: power_next = power_reg;
                    default:       power_next = 1'b0;
                endcase
                state_next = S_REF0;
            end
            S_REF0:
            begin
                alu_req.a  = tick_reg;
                alu_req.b  = rmark_reg;
                tmp_next   = alu_res.y;
                state_next = S_REF1;
            end
            S_REF1:
            begin
                alu_req.a  = tmp_reg;
                alu_req.b  = {{(ALU_W-REFRESH_W){1'b0}}, cfg.refresh_ticks};
                due_next   = !alu_res.borrow;
                state_next = alu_res.borrow ? S_POT0 : S_REF2;
            end
            S_REF2:
            begin
                alu_req.a   = rmark_reg;
                alu_req.b   = {{(ALU_W-REFRESH_W){1'b0}}, cfg.refresh_ticks};
                alu_req.sub = 1'b0;
                rmark_next  = alu_res.y;
                state_next  = S_POT0;
            end
            S_POT0:
            begin
                alu_req.a  = {{(ALU_W-POT_W){1'b0}}, pot_reg};
                alu_req.b  = {{(ALU_W-POT_W){1'b0}}, last_pot_reg};
                tmp_next   = alu_res.y;
                state_next = alu_res.borrow ? S_POT1 : S_THR;
            end
            S_POT1:
            begin
                // Pot moved down: take the difference the other way round
                alu_req.a  = {{(ALU_W-POT_W){1'b0}}, last_pot_reg};
                alu_req.b  = {{(ALU_W-POT_W){1'b0}}, pot_reg};
                tmp_next   = alu_res.y;
                state_next = S_THR;
            end
            S_THR:
            begin
                alu_req.a  = {{(ALU_W-THRESH_W){1'b0}}, cfg.change_threshold};
                alu_req.b  = tmp_reg;
                state_next = S_KEY;
                if (due_reg || alu_res.borrow)
                begin
                    last_pot_next = pot_reg;
                    if (power_reg)
                    begin
                        q_next     = num_calc;
                        rem_next   = '0;
                        d_next     = d_calc;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // One restoring division step: shift in the next numerator bit
                alu_req.a = {{(ALU_W-DEN_W-1){1'b0}}, rem_reg, q_reg[NUM_W-1]};
                alu_req.b = {{(ALU_W-DEN_W){1'b0}}, d_reg};
                if (alu_res.borrow)
                begin
                    rem_next = {rem_reg[DEN_W-2:0], q_reg[NUM_W-1]};
                    q_next   = {q_reg[NUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = alu_res.y[DEN_W-1:0];
                    q_next   = {q_reg[NUM_W-2:0], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                // Round up when the remainder exceeds half the divisor
                alu_req.a  = {{(ALU_W-DEN_W+1){1'b0}}, d_reg[DEN_W-1:1]};
                alu_req.b  = {{(ALU_W-DEN_W){1'b0}}, rem_reg};
                round_next = alu_res.borrow;
                state_next = S_INC;
            end
            S_INC:
            begin
                alu_req.a   = {{(ALU_W-NUM_W){1'b0}}, q_reg};
                alu_req.b   = {{(ALU_W-1){1'b0}}, round_reg};
                alu_req.sub = 1'b0;
                q_next      = alu_res.y[NUM_W-1:0];
                state_next  = S_CAP;
            end
            S_CAP:
            begin
                alu_req.a   = {{(ALU_W-PCT_W){1'b0}}, PCT_MAX};
                alu_req.b   = {{(ALU_W-NUM_W){1'b0}}, q_reg};
                pvalid_next = 1'b1;
                if (alu_res.borrow)
                begin
                    pct_next  = PCT_MAX;
                    duty_next = cfg.pwm_period;
                end
                else
                begin
                    pct_next  = q_reg[PCT_W-1:0];
                    duty_next = pot_reg;
                end
                state_next = S_KEY;
            end
            S_KEY:
            begin
                // Hold here while the previous result is still stalled
                if (slot_free)
                begin
                    out_data_next = {6'b0, pct_reg, power_reg, !key, key};
                    out_user_next = pvalid_reg;
                    m_valid_next  = 1'b1;
                    if ((cfg.pwm_period == '0) ||
                        (phase_inc >= {1'b0, cfg.pwm_period}))
                    begin
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_inc[PERIOD_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= '0;
            dmark_reg    <= '0;
            rmark_reg    <= '0;
            stable_reg   <= '0;
            power_reg    <= 1'b0;
            last_pot_reg <= '0;
            duty_reg     <= '0;
            pct_reg      <= '0;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            dmark_reg    <= dmark_next;
            rmark_reg    <= rmark_next;
            stable_reg   <= stable_next;
            power_reg    <= power_next;
            last_pot_reg <= last_pot_next;
            duty_reg     <= duty_next;
            pct_reg      <= pct_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload of the current tick and the output register
    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        pot_reg      <= pot_next;
        tmp_reg      <= tmp_next;
        due_reg      <= due_next;
        pvalid_reg   <= pvalid_next;
        round_reg    <= round_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        d_reg        <= d_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // An accepted tick always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_TICK))
        else $error("accepted tick did not start the sequencer");

    // A fresh percent is only reported with power on
    a_pvalid_power: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[2])
        else $error("percent_valid without power enabled");

    // The heater key never drives with power off
    a_key_power: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> m_tdata[2])
        else $error("heater key on while power is off");

    // The stored percent never exceeds the cap
    a_pct_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pct_reg <= PCT_MAX)
        else $error("percent above cap");

    // A result only loads from the final sequencer step
    a_load_from_key: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_KEY))
        else $error("result loaded outside the final step");

endmodule

/* design/hpc_cfg.sv */
// APB-style configuration registers of the heater PWM controller.
// Depends on hpc_pkg for the register map, widths and reset values.
module hpc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hpc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hpc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output hpc_pkg::cfg_t                  cfg
);
    import hpc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PWM_PERIOD:       cfg_next.pwm_period       = pwdata[PERIOD_W-1:0];
                REG_DEBOUNCE_TICKS:   cfg_next.debounce_ticks   = pwdata[DEBOUNCE_W-1:0];
                REG_REFRESH_TICKS:    cfg_next.refresh_ticks    = pwdata[REFRESH_W-1:0];
                REG_CHANGE_THRESHOLD: cfg_next.change_threshold = pwdata[THRESH_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period       <= RST_PWM_PERIOD;
            cfg_reg.debounce_ticks   <= RST_DEBOUNCE_TICKS;
            cfg_reg.refresh_ticks    <= RST_REFRESH_TICKS;
            cfg_reg.change_threshold <= RST_CHANGE_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PWM_PERIOD:
                prdata = {{(CFG_DATA_W-PERIOD_W){1'b0}}, cfg_reg.pwm_period};
            REG_DEBOUNCE_TICKS:
                prdata = {{(CFG_DATA_W-DEBOUNCE_W){1'b0}}, cfg_reg.debounce_ticks};
            REG_REFRESH_TICKS:
                prdata = {{(CFG_DATA_W-REFRESH_W){1'b0}}, cfg_reg.refresh_ticks};
            REG_CHANGE_THRESHOLD:
                prdata = {{(CFG_DATA_W-THRESH_W){1'b0}}, cfg_reg.change_threshold};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* design/hpc_alu.sv */
// Shared 32-bit adder/subtractor used by the arithmetic steps of the controller sequencer.
// Depends on hpc_pkg for the request and result structs.
module hpc_alu (
    input  hpc_pkg::alu_req_t req,
    output hpc_pkg::alu_res_t res
);
    import hpc_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   sum;

    // Subtract as a + ~b + 1; a missing carry out means a borrow.
    assign b_eff      = req.sub ? ~req.b : req.b;
    assign sum        = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};
    assign res.y      = sum[ALU_W-1:0];
    assign res.borrow = req.sub && !sum[ALU_W];

endmodule

/* test/testbench.sv */
// Self-checking testbench for heater_pwm_controller_top: directed ticks, then random runs.
// Depends on hpc_pkg and the design files; a scoreboard class predicts every result transfer.
import hpc_pkg::*;

// Raw button levels that the package does not name
localparam logic [BTN_W-1:0] BTN_LEVELS_START_LOW = 2'd2;
localparam logic [BTN_W-1:0] BTN_LEVELS_RELEASED  = 2'd3;

typedef struct packed {
    logic             key;
    logic             led;
    logic             power;
    logic [PCT_W-1:0] pct;
    logic             pct_valid;
} tick_result_t;

// Tracks the controller state tick by tick and holds the results still to come
class tick_scoreboard;
    bit [PERIOD_W-1:0]   period;
    bit [DEBOUNCE_W-1:0] debounce;
    bit [REFRESH_W-1:0]  refresh;
    bit [THRESH_W-1:0]   threshold;

    bit [TICK_W-1:0] tick_count;
    bit [TICK_W-1:0] debounce_mark;
    bit [TICK_W-1:0] refresh_mark;
    bit [POT_W-1:0]  phase;
    bit [POT_W-1:0]  last_pot;
    bit [POT_W-1:0]  duty;
    bit [BTN_W-1:0]  stable_buttons;
    bit              power_on;
    bit [PCT_W-1:0]  percent_reg;

    tick_result_t expected_ticks[$];
    int           fails;

    function new();
        period         = RST_PWM_PERIOD;
        debounce       = RST_DEBOUNCE_TICKS;
        refresh        = RST_REFRESH_TICKS;
        threshold      = RST_CHANGE_THRESHOLD;
        tick_count     = '0;
        debounce_mark  = '0;
        refresh_mark   = '0;
        phase          = '0;
        last_pot       = '0;
        duty           = '0;
        stable_buttons = '0;
        power_on       = 1'b0;
        percent_reg    = '0;
        fails          = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] value);
        case (idx)
            REG_PWM_PERIOD:       period    = value[PERIOD_W-1:0];
            REG_DEBOUNCE_TICKS:   debounce  = value[DEBOUNCE_W-1:0];
            REG_REFRESH_TICKS:    refresh   = value[REFRESH_W-1:0];
            REG_CHANGE_THRESHOLD: threshold = value[THRESH_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the state by one accepted tick and queue the result it causes
    function void note_tick(logic [BTN_W-1:0] btn, logic [POT_W-1:0] pot);
        tick_result_t r;
        bit [31:0]    den;
        bit [31:0]    num;
        bit [31:0]    pct;
        bit [POT_W-1:0] diff;
        bit           due;
        r = '0;
        tick_count = tick_count + 32'd1;

        // debounce: a changed level must persist for the debounce time
        if (btn != stable_buttons) begin
            if (tick_count - debounce_mark >= 32'(debounce)) begin
                debounce_mark  = debounce_mark + 32'(debounce);
                stable_buttons = btn;
                if (btn == BTN_CODE_ON)
                    power_on = 1'b1;
                else if (btn != BTN_CODE_HOLD)
                    power_on = 1'b0;
            end
        end
        else begin
            debounce_mark = tick_count;
        end

        // refresh on the interval or on a large pot move
        due = 1'b0;
        if (tick_count - refresh_mark >= 32'(refresh)) begin
            refresh_mark = refresh_mark + 32'(refresh);
            due = 1'b1;
        end
        diff = (pot >= last_pot) ? pot - last_pot : last_pot - pot;
        if (due || diff > threshold) begin
            last_pot = pot;
            if (power_on) begin
                den = (period > PERIOD_OFFSET ? 32'(period) - 32'(PERIOD_OFFSET) : 32'd1)
                      * 32'd10;
                num = 32'(pot) * 32'd1000;
                pct = num / den;
                if (num % den > den / 32'd2)
                    pct = pct + 32'd1;
                duty = pot;
                if (pct > 32'(PCT_MAX)) begin
                    pct  = 32'(PCT_MAX);
                    duty = period;
                end
                percent_reg = pct[PCT_W-1:0];
                r.pct_valid = 1'b1;
            end
        end

        r.key   = power_on && (phase < duty);
        r.led   = !r.key;
        r.power = power_on;
        r.pct   = percent_reg;

        if (period == '0 || 32'(phase) + 32'd1 >= 32'(period))
            phase = '0;
        else
            phase = phase + 1'b1;

        expected_ticks.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [15:0] tdata, logic tuser);
        tick_result_t got;
        tick_result_t want;
        got.key       = tdata[0];
        got.led       = tdata[1];
        got.power     = tdata[2];
        got.pct       = tdata[9:3];
        got.pct_valid = tuser;
        if (expected_ticks.size() == 0) begin
            if (fails < 10)
                $display("result with nothing expected: key=%b led=%b power=%b pct=%0d valid=%b",
                         got.key, got.led, got.power, got.pct, got.pct_valid);
            fails++;
            return;
        end
        want = expected_ticks.pop_front();
        if (got.key !== want.key || got.led !== want.led || got.power !== want.power ||
            got.pct !== want.pct || got.pct_valid !== want.pct_valid) begin
            if (fails < 10)
                $display("tick result mismatch: expected key=%b led=%b power=%b pct=%0d valid=%b, got key=%b led=%b power=%b pct=%0d valid=%b",
                         want.key, want.led, want.power, want.pct, want.pct_valid,
                         got.key, got.led, got.power, got.pct, got.pct_valid);
            fails++;
        end
    endfunction
endclass

module testbench;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [1:0] button_levels, [13:2] pot_code, [15:14] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [0] heater_key, [1] led_out, [2] power_enabled,
                            // [9:3] percent, [15:10] zero
    logic        m_tuser;   // [0] percent_valid

    tick_scoreboard sb = new();

    // Long receiver hold-off, requested by the stimulus and counted by the receiver
    int holdoff_cycles = 0;

    heater_pwm_controller_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Abort a hung run
    initial
    begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

    // Check every result transfer as it completes
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tdata, m_tuser);
    end

    // Receiver: switch between stall patterns, and serve the long hold-off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (holdoff_cycles) @(posedge clk);
                holdoff_cycles = 0;
            end
            else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (left % 5 == 0);
                endcase
            end
        end
    end

    // Offer one tick and hold it until the transfer completes; keep tvalid high afterwards
    task automatic send_tick(logic [BTN_W-1:0] btn, logic [POT_W-1:0] pot);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pot, btn};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_tick(btn, pot);
    endtask

    // Setup and access cycle; psel stays high so writes can follow back to back
    task automatic write_reg(logic [1:0] idx, int unsigned value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_reg(idx, value);
    endtask

    // Drain the block, then rewrite all four registers while it is idle
    task automatic apply_cfg(int unsigned period, int unsigned debounce,
                             int unsigned refresh, int unsigned threshold);
        s_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_DEBOUNCE_TICKS, debounce);
        write_reg(REG_REFRESH_TICKS, refresh);
        write_reg(REG_CHANGE_THRESHOLD, threshold);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random ticks: button runs that mostly outlast the debounce time, a drifting pot
    // with jumps, and sender bursts separated by gaps
    task automatic run_ticks(int n_items, int hold_at, int pause_at);
        int             run_left;
        int             burst_left;
        int             gap;
        int             pot_level;
        int             step;
        int             pick;
        logic [BTN_W-1:0] code;
        logic [BTN_W-1:0] btn;
        run_left   = 0;
        burst_left = 0;
        code       = BTN_CODE_ON;
        pot_level  = $urandom_range(0, 4095);
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    code = BTN_CODE_ON;
                else if (pick < 7)
                    code = BTN_LEVELS_RELEASED;
                else if (pick == 7)
                    code = BTN_LEVELS_START_LOW;
                else
                    code = BTN_CODE_HOLD;
                // now and then a press no longer than the debounce time, mostly too short to register
                if (sb.debounce != 0 && $urandom_range(0, 4) == 0)
                    run_left = $urandom_range(1, sb.debounce);
                else
                    run_left = sb.debounce + $urandom_range(1, 20);
            end
            run_left--;
            btn = ($urandom_range(0, 14) == 0) ? BTN_W'($urandom_range(0, 3)) : code;

            pick = $urandom_range(0, 11);
            if (pick == 0)
                pot_level = $urandom_range(0, 1) ? 4095 : 0;
            else if (pick <= 2)
                pot_level = $urandom_range(0, 4095);
            else begin
                // steps on both sides of the change threshold
                step = $urandom_range(0, int'(sb.threshold) + int'(sb.threshold) / 4 + 2);
                pot_level = $urandom_range(0, 1) ? pot_level + step : pot_level - step;
                if (pot_level < 0)
                    pot_level = 0;
                if (pot_level > 4095)
                    pot_level = 4095;
            end

            if (i == hold_at)
                holdoff_cycles = 400;

            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst_left--;
            if (i == pause_at && gap == 0)
                gap = 1;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
                // pause the sender until the block has delivered everything
                if (i == pause_at)
                    while (sb.expected_ticks.size() != 0) @(posedge clk);
            end
            send_tick(btn, POT_W'(pot_level));
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        int wait_cycles;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: power off, nothing latched yet
        send_tick(BTN_LEVELS_RELEASED, 12'd0);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_CODE_HOLD, 12'd2048);

        // Shortest period above the offset, no debounce, refresh every tick: every button code,
        // capped percent and full duty
        apply_cfg(6, 0, 1, 0);
        send_tick(BTN_LEVELS_RELEASED, 12'd0);
        send_tick(BTN_CODE_ON, 12'd0);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_CODE_ON, 12'd1);
        send_tick(BTN_CODE_HOLD, 12'd2048);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_LEVELS_START_LOW, 12'd5);
        send_tick(BTN_CODE_ON, 12'd3000);
        send_tick(BTN_LEVELS_RELEASED, 12'd3000);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_CODE_ON, 12'd10);

        // Zero period holds the phase, zero refresh interval refreshes every tick
        apply_cfg(0, 0, 0, 4095);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_CODE_ON, 12'd2);
        send_tick(BTN_CODE_ON, 12'd4095);
        send_tick(BTN_LEVELS_RELEASED, 12'd0);

        // Period at the offset, longest debounce: a pot move refreshes with power off
        apply_cfg(5, 1000, 65535, 3000);
        send_tick(BTN_CODE_ON, 12'd100);
        send_tick(BTN_LEVELS_START_LOW, 12'd4095);

        // Divisor 800: remainder exactly half stays, above half rounds up, 101 caps
        apply_cfg(85, 0, 1, 0);
        send_tick(BTN_CODE_ON, 12'd2);
        send_tick(BTN_CODE_ON, 12'd3);
        send_tick(BTN_CODE_ON, 12'd68);
        send_tick(BTN_CODE_ON, 12'd81);
        send_tick(BTN_CODE_ON, 12'd80);

        // Random phases over several register settings, extremes included
        apply_cfg(2975, 30, 500, 100);
        run_ticks(150, 40, 100);
        apply_cfg(6, 0, 1, 0);
        run_ticks(100, -1, 60);
        apply_cfg($urandom_range(6, 300), $urandom_range(0, 10), $urandom_range(1, 50),
                  $urandom_range(0, 600));
        run_ticks(100, 70, 30);
        apply_cfg(4095, 4, 65535, 4095);
        run_ticks(100, -1, -1);
        apply_cfg($urandom_range(6, 120), $urandom_range(0, 6), $urandom_range(1, 20),
                  $urandom_range(0, 300));
        run_ticks(150, -1, 90);

        // Drain, then allow for the longest tick before judging
        wait_cycles = 0;
        while (sb.expected_ticks.size() != 0 && wait_cycles < 5000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (sb.expected_ticks.size() != 0)
            $display("results never delivered: %0d", sb.expected_ticks.size());
        sb.fails += sb.expected_ticks.size();

        if (sb.fails == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
